>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the touch classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define ASSERT_ON_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ttsc_pkg.sv
// Types, constants and helper functions of the touch tap/swipe classifier
`timescale 1ns / 1ps
`default_nettype none

package ttsc_pkg;

  localparam int COORD_W  = 16;
  localparam int ZONE_W   = 9;
  localparam int DELAY_W  = 3;
  localparam int MAG_W    = 6;
  localparam int DIR_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = ZONE_W;

  localparam logic [COORD_W-1:0] NO_READING = 16'hFFFF;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DEC  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_INC  = 2'd2;

  // Register reset values
  localparam logic [ZONE_W-1:0]  RST_RIGHT_X_LOW  = 9'd192;
  localparam logic [ZONE_W-1:0]  RST_RIGHT_X_HIGH = 9'd256;
  localparam logic [ZONE_W-1:0]  RST_LEFT_X_HIGH  = 9'd64;
  localparam logic [ZONE_W-1:0]  RST_ZONE_Y_LOW   = 9'd160;
  localparam logic [ZONE_W-1:0]  RST_ZONE_Y_HIGH  = 9'd184;
  localparam logic [DELAY_W-1:0] RST_HOLD_DELAY   = 3'd4;
  localparam logic [MAG_W-1:0]   RST_TAP_LIMIT    = 6'd4;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIGHT_X_LOW  = 3'd0,
    REG_RIGHT_X_HIGH = 3'd1,
    REG_LEFT_X_HIGH  = 3'd2,
    REG_ZONE_Y_LOW   = 3'd3,
    REG_ZONE_Y_HIGH  = 3'd4,
    REG_HOLD_DELAY   = 3'd5,
    REG_TAP_LIMIT    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [ZONE_W-1:0]  right_zone_x_low;
    logic [ZONE_W-1:0]  right_zone_x_high;
    logic [ZONE_W-1:0]  left_zone_x_high;
    logic [ZONE_W-1:0]  zone_y_low;
    logic [ZONE_W-1:0]  zone_y_high;
    logic [DELAY_W-1:0] hold_delay;
    logic [MAG_W-1:0]   tap_move_limit;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;
    logic               touch_new;
    logic               touch_held;
  } sample_t;

  typedef struct packed {
    logic             tap;
    logic             right_zone_press;
    logic             left_zone_press;
    logic [DIR_W-1:0] horiz_dir;
    logic [DIR_W-1:0] vert_dir;
    logic [MAG_W-1:0] horiz_mag;
    logic [MAG_W-1:0] vert_mag;
  } result_t;

  typedef struct packed {
    logic               hold_phase;
    logic [DELAY_W-1:0] hold_countdown;
    logic [COORD_W-1:0] anchor_x;
    logic [COORD_W-1:0] anchor_y;
    logic [MAG_W-1:0]   last_mag_x;
    logic [MAG_W-1:0]   last_mag_y;
  } hold_state_t;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic [MAG_W-1:0] mag;
  } motion_t;

  // Direction and wrapped magnitude of one axis; a fall is ones-complemented
  function automatic motion_t axis_motion(input logic [COORD_W-1:0] pos,
                                          input logic [COORD_W-1:0] anchor);
    motion_t            m;
    logic [COORD_W-1:0] diff;
    m = '0;
    diff = '0;
    if (pos != NO_READING) begin
      if (pos < anchor) begin
        diff = anchor - pos - COORD_W'(1);
        m.dir = DIR_DEC;
        m.mag = diff[MAG_W-1:0];
      end else if (pos > anchor) begin
        diff = pos - anchor;
        m.dir = DIR_INC;
        m.mag = diff[MAG_W-1:0];
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ttsc_if.sv
// Request channel interfaces: touch samples in, classification results out
`timescale 1ns / 1ps
`default_nettype none

interface ttsc_in_if import ttsc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] touch_x;
  logic [COORD_W-1:0] touch_y;
  logic               touch_new;
  logic               touch_held;

  modport source (output valid, touch_x, touch_y, touch_new, touch_held, input ready);
  modport sink   (input valid, touch_x, touch_y, touch_new, touch_held, output ready);
endinterface

interface ttsc_out_if import ttsc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             tap;
  logic             right_zone_press;
  logic             left_zone_press;
  logic [DIR_W-1:0] horiz_dir;
  logic [DIR_W-1:0] vert_dir;
  logic [MAG_W-1:0] horiz_mag;
  logic [MAG_W-1:0] vert_mag;

  modport source (output valid, tap, right_zone_press, left_zone_press, horiz_dir,
                  vert_dir, horiz_mag, vert_mag, input ready);
  modport sink   (input valid, tap, right_zone_press, left_zone_press, horiz_dir,
                  vert_dir, horiz_mag, vert_mag, output ready);
endinterface

`default_nettype wire

>>> rtl/ttsc_cfg_regs.sv
// Configuration register bank of the touch classifier
`timescale 1ns / 1ps
`default_nettype none

module ttsc_cfg_regs import ttsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_RIGHT_X_LOW:  cfg_nxt.right_zone_x_low  = cfg_wdata;
        REG_RIGHT_X_HIGH: cfg_nxt.right_zone_x_high = cfg_wdata;
        REG_LEFT_X_HIGH:  cfg_nxt.left_zone_x_high  = cfg_wdata;
        REG_ZONE_Y_LOW:   cfg_nxt.zone_y_low        = cfg_wdata;
        REG_ZONE_Y_HIGH:  cfg_nxt.zone_y_high       = cfg_wdata;
        REG_HOLD_DELAY:   cfg_nxt.hold_delay        = cfg_wdata[DELAY_W-1:0];
        REG_TAP_LIMIT:    cfg_nxt.tap_move_limit    = cfg_wdata[MAG_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.right_zone_x_low  <= RST_RIGHT_X_LOW;
      cfg_r.right_zone_x_high <= RST_RIGHT_X_HIGH;
      cfg_r.left_zone_x_high  <= RST_LEFT_X_HIGH;
      cfg_r.zone_y_low        <= RST_ZONE_Y_LOW;
      cfg_r.zone_y_high       <= RST_ZONE_Y_HIGH;
      cfg_r.hold_delay        <= RST_HOLD_DELAY;
      cfg_r.tap_move_limit    <= RST_TAP_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/ttsc_core.sv
// Classification logic and hold/anchor state of the touch classifier
`timescale 1ns / 1ps
`default_nettype none

module ttsc_core import ttsc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,   // sample in the input register is consumed this cycle
  input  wire sample_t smp,
  input  wire cfg_t    cfg,
  output result_t      res
);

  hold_state_t state_r;
  hold_state_t state_nxt;

  logic               y_in;
  logic               in_right;
  logic               in_left;
  logic               in_zone;
  logic               fresh;
  logic [COORD_W-1:0] anc_x;
  logic [COORD_W-1:0] anc_y;
  motion_t            mot_x;
  motion_t            mot_y;

  // Button rectangle hits; the right one wins on overlap
  assign y_in     = (smp.touch_y >= COORD_W'(cfg.zone_y_low)) &&
                    (smp.touch_y <= COORD_W'(cfg.zone_y_high));
  assign in_right = y_in && (smp.touch_x >= COORD_W'(cfg.right_zone_x_low)) &&
                    (smp.touch_x <= COORD_W'(cfg.right_zone_x_high));
  assign in_left  = !in_right && y_in && (smp.touch_x <= COORD_W'(cfg.left_zone_x_high));
  assign in_zone  = in_right || in_left;

  // New touch outside the buttons re-anchors before motion is measured
  assign fresh = smp.touch_new && !in_zone;
  assign anc_x = fresh ? smp.touch_x : state_r.anchor_x;
  assign anc_y = fresh ? smp.touch_y : state_r.anchor_y;
  assign mot_x = axis_motion(smp.touch_x, anc_x);
  assign mot_y = axis_motion(smp.touch_y, anc_y);

  // Next state and result of one sample
  always_comb begin
    state_nxt = state_r;
    res       = '0;
    if (smp.touch_new) begin
      if (in_zone) begin
        res.right_zone_press = in_right;
        res.left_zone_press  = in_left;
      end else begin
        state_nxt.hold_phase     = 1'b0;
        state_nxt.last_mag_x     = '0;
        state_nxt.last_mag_y     = '0;
        state_nxt.anchor_x       = smp.touch_x;
        state_nxt.anchor_y       = smp.touch_y;
        state_nxt.hold_countdown = cfg.hold_delay;
      end
    end
    if (!(smp.touch_new && in_zone)) begin
      if (smp.touch_held) begin
        // countdown runs until it expires, then the phase latches
        if (!state_nxt.hold_phase) begin
          if (state_nxt.hold_countdown == '0) begin
            state_nxt.hold_phase = 1'b1;
          end else begin
            state_nxt.hold_countdown = state_nxt.hold_countdown - DELAY_W'(1);
          end
        end
        if (!in_zone) begin
          res.horiz_dir        = mot_x.dir;
          res.horiz_mag        = mot_x.mag;
          res.vert_dir         = mot_y.dir;
          res.vert_mag         = mot_y.mag;
          state_nxt.last_mag_x = mot_x.mag;
          state_nxt.last_mag_y = mot_y.mag;
          state_nxt.anchor_x   = smp.touch_x;
          state_nxt.anchor_y   = smp.touch_y;
        end
      end else begin
        // release: tap when quick and nearly still
        res.tap = !in_zone && (state_nxt.hold_countdown != '0) &&
                  (state_nxt.last_mag_x < cfg.tap_move_limit) &&
                  (state_nxt.last_mag_y < cfg.tap_move_limit);
        state_nxt.hold_phase     = 1'b0;
        state_nxt.last_mag_x     = '0;
        state_nxt.last_mag_y     = '0;
        state_nxt.hold_countdown = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/touch_tap_swipe_classifier_unit.sv
// Touch tap/swipe classifier: top level with input and result registers
//
// Usage:
//   in_if  : one touch sample per request (touch_x, touch_y, touch_new, touch_held),
//            taken at a rising edge with valid and ready both high.
//   out_if : exactly one result per sample (tap, button presses, per-axis
//            direction and 6-bit magnitude), in sample order.
//   cfg_*  : register writes (cfg_we, cfg_index, cfg_wdata); write only while
//            no sample is in flight.
//   Path:    an accepted sample waits in the input register, is classified
//            combinationally and goes to the result register, raising out_if.valid,
//            once that register is free.
//   Throughput: one sample per cycle while out_if.ready stays high; the hold
//            state updates as each sample moves into the result register, ready
//            for the next one.
//   Reset (rst_n low, synchronous): registers take their default values,
//            hold state and anchors clear, both stages empty.
//   Stall: while out_if.ready is low the result holds; one more sample can
//            wait in the input register, after which in_if.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module touch_tap_swipe_classifier_unit import ttsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ttsc_in_if.sink                    in_if,
  ttsc_out_if.source                 out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  sample_t smp_r;
  sample_t smp_nxt;
  logic    smp_valid_r;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    step;
  logic    in_take;

  ttsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ttsc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .smp   (smp_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Handshake: input stage drains whenever the result register is free
  assign step        = smp_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !smp_valid_r || step;
  assign in_take     = in_if.valid && in_if.ready;

  assign smp_nxt.touch_x    = in_if.touch_x;
  assign smp_nxt.touch_y    = in_if.touch_y;
  assign smp_nxt.touch_new  = in_if.touch_new;
  assign smp_nxt.touch_held = in_if.touch_held;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      smp_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r <= smp_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.tap              = out_r.tap;
  assign out_if.right_zone_press = out_r.right_zone_press;
  assign out_if.left_zone_press  = out_r.left_zone_press;
  assign out_if.horiz_dir        = out_r.horiz_dir;
  assign out_if.vert_dir         = out_r.vert_dir;
  assign out_if.horiz_mag        = out_r.horiz_mag;
  assign out_if.vert_mag         = out_r.vert_mag;

endmodule

`default_nettype wire

>>> rtl/ttsc_checker.sv
// Port-level checks of the touch classifier, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttsc_checker import ttsc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             tap,
  input wire logic             right_zone_press,
  input wire logic             left_zone_press,
  input wire logic [DIR_W-1:0] horiz_dir,
  input wire logic [DIR_W-1:0] vert_dir,
  input wire logic [MAG_W-1:0] horiz_mag,
  input wire logic [MAG_W-1:0] vert_mag
);

  // Reset empties the result stage
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result stays put
  `ASSERT_ON_RUN(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable({tap, right_zone_press, left_zone_press, horiz_dir, vert_dir, horiz_mag, vert_mag}), "stalled result changed")

  // Tap and button presses exclude each other
  `ASSERT_ON_RUN(a_events_excl, out_valid |-> $onehot0({tap, right_zone_press, left_zone_press}), "more than one event flagged")

  // A press or a tap carries no motion
  `ASSERT_ON_RUN(a_event_still, out_valid && (tap || right_zone_press || left_zone_press) |-> horiz_dir == DIR_NONE && vert_dir == DIR_NONE, "motion reported with an event")

  // No direction means no magnitude
  `ASSERT_ON_RUN(a_mag_dir, out_valid && horiz_dir == DIR_NONE && vert_dir == DIR_NONE |-> horiz_mag == '0 && vert_mag == '0, "magnitude without direction")

endmodule

bind touch_tap_swipe_classifier_unit ttsc_checker u_ttsc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .tap              (out_if.tap),
  .right_zone_press (out_if.right_zone_press),
  .left_zone_press  (out_if.left_zone_press),
  .horiz_dir        (out_if.horiz_dir),
  .vert_dir         (out_if.vert_dir),
  .horiz_mag        (out_if.horiz_mag),
  .vert_mag         (out_if.vert_mag)
);

`default_nettype wire
